// ===== design/assert_macros.svh =====
// assertion macros for the decoder rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is held (reset is active low)
`define MMBD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define MMBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/mmbd_pkg.sv =====
// package for the masked match byte decoder: sizes, codes and the token
// that travels along the cell row; no dependencies
package mmbd_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int WORDS   = 8;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WSEL_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LIMIT_W = $clog2(ENTRIES + 1);
    localparam int CNT_W   = $clog2(WORDS + 1);

    // field widths
    localparam int ENTRY_FIELD_W = 4;
    localparam int WIDX_FIELD_W  = 3;
    localparam int DATA_W        = 64;
    localparam int BYTE_W        = 8;
    localparam int STATUS_W      = 2;

    // stream widths
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 8;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int ENTRY_COUNT_W     = 5;
    localparam int CONTAINER_WORDS_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTAINER_WORDS = 2'd1;
    localparam logic [ENTRY_COUNT_W-1:0]     ENTRY_COUNT_RST     = 5'd10;
    localparam logic [CONTAINER_WORDS_W-1:0] CONTAINER_WORDS_RST = 4'd8;

    // decimal assembly
    localparam int DIGITS_PER_BYTE = 3;
    localparam int WEIGHT_HUNDREDS = 100;
    localparam int WEIGHT_TENS     = 10;
    localparam int BYTE_MAX        = 255;
    localparam int VAL_W           = 16;
    localparam int POS_W           = 2;

    // input item kinds
    localparam logic KIND_LOAD      = 1'b0;
    localparam logic KIND_CONTAINER = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_MISS  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_WORD = 2'd1,
        OP_END  = 2'd2
    } op_t;

    // request token handed from cell to cell
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [IDX_W-1:0]  entry;
        logic [WSEL_W-1:0] widx;
        logic [DATA_W-1:0] data_a;   // key word on load, container word otherwise
        logic [DATA_W-1:0] data_b;   // masked etalon word on load
        logic              found;
        logic [IDX_W-1:0]  digit;
    } token_t;

endpackage

// ===== design/masked_match_byte_decoder_unit.sv =====
// top level of the masked match byte decoder: input classification,
// configuration registers, cell row and byte assembly; depends on mmbd_pkg,
// mmbd_cell and mmbd_assemble
//
//  channel   direction  payload
//  s_        in         tuser: kind; tdata: entry, word_index, etalon, key, container
//  m_        out        tdata: byte_value; tuser: status
//  cfg_      in         write enable, register index, write data
//
// one request per cycle is taken while the skid stage is empty; the row of
// ENTRIES cells passes each request one cell per clock unless frozen, and the
// request ending the third container reaches m_tvalid via tok0_reg, the cells
// and the output register. reset clears the pipeline valids and digit state
// and sets the candidate flags; the table words hold nothing defined until loaded.
// an output stall fills the skid stage, which then freezes the whole row.
module masked_match_byte_decoder_unit
    import mmbd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // entry, word_index, etalon_word, key_word, container_word
    input  logic                   s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // byte_value
    output logic [STATUS_W-1:0]    m_tuser,   // status
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int ENTRY_LO = 0;
    localparam int WIDX_LO  = ENTRY_LO + ENTRY_FIELD_W;
    localparam int ETAL_LO  = WIDX_LO + WIDX_FIELD_W;
    localparam int KEY_LO   = ETAL_LO + DATA_W;
    localparam int CONT_LO  = KEY_LO + DATA_W;

    logic [ENTRY_COUNT_W-1:0]     entry_count_reg;
    logic [CONTAINER_WORDS_W-1:0] container_words_reg;
    token_t                       tok0_reg, tok0_next;
    token_t                       tok [ENTRIES+1];

    logic                     advance;
    logic                     accept;
    logic [LIMIT_W-1:0]       limit;
    logic [CNT_W-1:0]         eff_words;
    logic [ENTRY_FIELD_W-1:0] in_entry;
    logic [WIDX_FIELD_W-1:0]  in_widx;
    logic [DATA_W-1:0]        in_etalon;
    logic [DATA_W-1:0]        in_key;
    logic [DATA_W-1:0]        in_cont;

    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    assign in_entry  = s_tdata[ENTRY_LO +: ENTRY_FIELD_W];
    assign in_widx   = s_tdata[WIDX_LO +: WIDX_FIELD_W];
    assign in_etalon = s_tdata[ETAL_LO +: DATA_W];
    assign in_key    = s_tdata[KEY_LO +: DATA_W];
    assign in_cont   = s_tdata[CONT_LO +: DATA_W];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg     <= ENTRY_COUNT_RST;
            container_words_reg <= CONTAINER_WORDS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENTRY_COUNT:     entry_count_reg     <= cfg_wr_data[ENTRY_COUNT_W-1:0];
                CFG_CONTAINER_WORDS: container_words_reg <= cfg_wr_data[CONTAINER_WORDS_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated search limit and container length
    always_comb begin
        if (32'(entry_count_reg) < ENTRIES) begin
            limit = LIMIT_W'(entry_count_reg);
        end else begin
            limit = LIMIT_W'(ENTRIES);
        end
        if (container_words_reg == '0) begin
            eff_words = CNT_W'(1);
        end else if (32'(container_words_reg) > WORDS) begin
            eff_words = CNT_W'(WORDS);
        end else begin
            eff_words = CNT_W'(container_words_reg);
        end
    end

    // classify the request into a token for the row
    always_comb begin
        tok0_next        = '0;
        tok0_next.entry  = IDX_W'(in_entry);
        tok0_next.widx   = WSEL_W'(in_widx);
        tok0_next.found  = 1'b0;
        tok0_next.digit  = '0;
        if (s_tuser == KIND_LOAD) begin
            tok0_next.op     = OP_LOAD;
            tok0_next.data_a = in_key;
            tok0_next.data_b = in_etalon & in_key;
            tok0_next.valid  = accept && (32'(in_entry) < ENTRIES) && (32'(in_widx) < WORDS);
        end else begin
            tok0_next.op     = (32'(in_widx) == 32'(eff_words) - 1) ? OP_END : OP_WORD;
            tok0_next.data_a = in_cont;
            tok0_next.valid  = accept && (32'(in_widx) < WORDS)
                               && (32'(in_widx) < 32'(eff_words));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok0_reg.valid <= 1'b0;
        end else if (advance) begin
            tok0_reg <= tok0_next;
        end
    end

    assign tok[0] = tok0_reg;

    // row of entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mmbd_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .cell_index (IDX_W'(g)),
            .limit      (limit),
            .tok_in     (tok[g]),
            .tok_out    (tok[g+1])
        );
    end

    // digit gathering and output
    mmbd_assemble u_assemble (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tok_in   (tok[ENTRIES]),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/mmbd_cell.sv =====
// one table entry of the decoder row: key and masked words, candidate flag
// depends on mmbd_pkg
module mmbd_cell
    import mmbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [IDX_W-1:0]   cell_index,
    input  logic [LIMIT_W-1:0] limit,
    input  token_t             tok_in,
    output token_t             tok_out
);

    logic [DATA_W-1:0] key_mem    [WORDS];
    logic [DATA_W-1:0] masked_mem [WORDS];
    logic              flag_reg;
    token_t            tok_reg;

    logic   hit;
    logic   flag_now;
    logic   in_range;
    logic   take;
    logic   load_here;
    token_t tok_next;

    // compare the incoming word against this entry's slot
    always_comb begin
        hit       = (tok_in.data_a & key_mem[tok_in.widx]) == masked_mem[tok_in.widx];
        flag_now  = flag_reg & hit;
        in_range  = LIMIT_W'(cell_index) < limit;
        take      = tok_in.valid && (tok_in.op == OP_END) && !tok_in.found
                    && flag_now && in_range;
        load_here = tok_in.valid && (tok_in.op == OP_LOAD) && (tok_in.entry == cell_index);
        tok_next  = tok_in;
        if (take) begin
            tok_next.found = 1'b1;
            tok_next.digit = cell_index;
        end
    end

    // token and candidate flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            flag_reg      <= 1'b1;
        end else if (advance) begin
            tok_reg <= tok_next;
            if (tok_in.valid) begin
                case (tok_in.op)
                    OP_WORD: flag_reg <= flag_now;
                    OP_END:  flag_reg <= 1'b1;
                    default: flag_reg <= flag_reg;
                endcase
            end
        end
    end

    // table storage for this entry
    always_ff @(posedge aclk) begin
        if (advance && load_here) begin
            key_mem[tok_in.widx]    <= tok_in.data_a;
            masked_mem[tok_in.widx] <= tok_in.data_b;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/mmbd_assemble.sv =====
// end of the row: gathers three digits into a byte and holds results in
// an output register with a skid stage; depends on mmbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module mmbd_assemble
    import mmbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  token_t               tok_in,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // byte_value
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [IDX_W-1:0] hold0_reg, hold0_next;
    logic [IDX_W-1:0] hold1_reg, hold1_next;
    logic             miss_reg,  miss_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    status_t           out_status_reg;
    logic              skid_valid_reg;
    logic [BYTE_W-1:0] skid_byte_reg;
    status_t           skid_status_reg;

    logic              push;
    logic [IDX_W-1:0]  digit;
    logic              miss;
    logic [VAL_W-1:0]  value;
    logic [BYTE_W-1:0] res_byte;
    status_t           res_status;

    assign advance = !skid_valid_reg;

    // digit collection and byte formation
    always_comb begin
        pos_next   = pos_reg;
        hold0_next = hold0_reg;
        hold1_next = hold1_reg;
        miss_next  = miss_reg;
        push       = 1'b0;
        digit      = tok_in.found ? tok_in.digit : '0;
        miss       = miss_reg | !tok_in.found;
        value      = VAL_W'(32'(hold0_reg) * WEIGHT_HUNDREDS + 32'(hold1_reg) * WEIGHT_TENS
                            + 32'(digit));
        res_byte   = '0;
        res_status = STATUS_OK;
        if (miss) begin
            res_status = STATUS_MISS;
        end else if (32'(value) > BYTE_MAX) begin
            res_status = STATUS_RANGE;
        end else begin
            res_byte = value[BYTE_W-1:0];
        end
        if (advance && tok_in.valid && tok_in.op == OP_END) begin
            if (32'(pos_reg) == DIGITS_PER_BYTE - 1) begin
                push       = 1'b1;
                pos_next   = '0;
                hold0_next = '0;
                hold1_next = '0;
                miss_next  = 1'b0;
            end else begin
                if (pos_reg == '0) begin
                    hold0_next = digit;
                end else begin
                    hold1_next = digit;
                end
                pos_next  = pos_reg + 1'b1;
                miss_next = miss;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            hold0_reg <= '0;
            hold1_reg <= '0;
            miss_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            hold0_reg <= hold0_next;
            hold1_reg <= hold1_next;
            miss_reg  <= miss_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_tready) begin
            // output taken: refill from the skid stage, else from a new result, else go empty
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
                out_byte_reg   <= skid_byte_reg;
                out_status_reg <= skid_status_reg;
            end else if (push) begin
                out_byte_reg   <= res_byte;
                out_status_reg <= res_status;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_valid_reg  <= 1'b1;
                skid_byte_reg   <= res_byte;
                skid_status_reg <= res_status;
            end else begin
                out_valid_reg  <= 1'b1;
                out_byte_reg   <= res_byte;
                out_status_reg <= res_status;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

    // checks
    `MMBD_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg, "skid full while output empty")
    `MMBD_ASSERT(a_pos_bound, aclk, aresetn, 32'(pos_reg) < DIGITS_PER_BYTE, "digit position past third container")
    `MMBD_ASSERT(a_err_zero, aclk, aresetn, (out_valid_reg && out_status_reg != STATUS_OK) |-> (out_byte_reg == '0), "error result carries a nonzero byte")
    `MMBD_ASSERT(a_no_push_stalled, aclk, aresetn, skid_valid_reg |=> !(skid_valid_reg && $past(push)), "result pushed while skid full")

endmodule

// ===== tb/tb_masked_match_byte_decoder_unit.sv =====
// self-checking testbench for masked_match_byte_decoder_unit: directed and random
// table loads and containers, with its own decode predictor; depends on mmbd_pkg
// and the decoder rtl only
module tb_masked_match_byte_decoder_unit;
    import mmbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 2 * ENTRIES + 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        status_t           status;
    } decoded_byte_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;  // entry, word_index, etalon, key, container, pad
    logic                   s_tuser     = 1'b0; // kind
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;           // byte_value
    logic [STATUS_W-1:0]    m_tuser;           // status
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    // traffic shaping
    logic        idle_on    = 1'b1;
    logic        hold_req   = 1'b0;
    logic        hold_ack   = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;

    // predictor state
    logic [DATA_W-1:0]  key_tbl [ENTRIES][WORDS];
    logic [DATA_W-1:0]  ref_tbl [ENTRIES][WORDS];
    logic [ENTRIES-1:0] live_entries        = '1;
    int unsigned        container_pos       = 0;
    int unsigned        held_digit [2]      = '{0, 0};
    bit                 any_miss            = 1'b0;
    int unsigned        cfg_entry_count     = ENTRY_COUNT_RST;
    int unsigned        cfg_container_words = CONTAINER_WORDS_RST;

    decoded_byte_t pending_bytes [$];
    decoded_byte_t want;
    int unsigned   decode_items = 0;
    int unsigned   quiet_cycles = 0;
    int            fail_count   = 0;

    masked_match_byte_decoder_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // container length as the block sees it
    function automatic int unsigned effective_words();
        int unsigned n;
        n = cfg_container_words;
        if (n == 0) n = 1;
        if (n > WORDS) n = WORDS;
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly dense keys, now and then an empty or a full one
    function automatic logic [DATA_W-1:0] rand_key();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // a word that matches the given entry at slot w; a negative digit gives noise
    function automatic logic [DATA_W-1:0] container_word(input int digit, input int w);
        if (digit < 0) return rand64();
        return (rand64() & ~key_tbl[digit][w]) | ref_tbl[digit][w];
    endfunction

    // decode predictor: table writes, candidate narrowing and byte assembly
    function automatic void decode_predict(input logic kind,
            input logic [ENTRY_FIELD_W-1:0] entry, input logic [WIDX_FIELD_W-1:0] widx,
            input logic [DATA_W-1:0] etalon, input logic [DATA_W-1:0] key,
            input logic [DATA_W-1:0] word);
        int unsigned   n;
        int unsigned   limit;
        int unsigned   digit;
        int unsigned   value;
        bit            found;
        decoded_byte_t res;
        n     = effective_words();
        digit = 0;
        found = 1'b0;
        if (kind == KIND_LOAD) begin
            key_tbl[entry][widx] = key;
            ref_tbl[entry][widx] = etalon & key;
            return;
        end
        if (widx >= n) return;
        for (int e = 0; e < ENTRIES; e++)
            if ((word & key_tbl[e][widx]) != ref_tbl[e][widx]) live_entries[e] = 1'b0;
        if (widx != n - 1) return;
        // container end: lowest surviving entry within the searched range
        limit = (cfg_entry_count < ENTRIES) ? cfg_entry_count : ENTRIES;
        for (int e = 0; e < limit; e++) begin
            if (!found && live_entries[e]) begin
                digit = e;
                found = 1'b1;
            end
        end
        if (!found) any_miss = 1'b1;
        live_entries = '1;
        if (container_pos < DIGITS_PER_BYTE - 1) begin
            held_digit[container_pos] = digit;
            container_pos++;
            return;
        end
        value = held_digit[0] * WEIGHT_HUNDREDS + held_digit[1] * WEIGHT_TENS + digit;
        if (any_miss) begin
            res.byte_value = '0;
            res.status     = STATUS_MISS;
        end else if (value > BYTE_MAX) begin
            res.byte_value = '0;
            res.status     = STATUS_RANGE;
        end else begin
            res.byte_value = value[BYTE_W-1:0];
            res.status     = STATUS_OK;
        end
        pending_bytes.push_back(res);
        container_pos = 0;
        held_digit    = '{0, 0};
        any_miss      = 1'b0;
    endfunction

    // offer one request, wait for it to be taken, then predict
    task automatic send_request(input logic kind, input logic [ENTRY_FIELD_W-1:0] entry,
            input logic [WIDX_FIELD_W-1:0] widx, input logic [DATA_W-1:0] etalon,
            input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] word);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, word, key, etalon, widx, entry};
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_LOAD || widx < effective_words()) decode_items++;
        decode_predict(kind, entry, widx, etalon, key, word);
    endtask

    task automatic load_word(input int entry, input int w, input logic [DATA_W-1:0] etalon,
            input logic [DATA_W-1:0] key);
        send_request(KIND_LOAD, entry, w, etalon, key, rand64());
    endtask

    task automatic send_word(input int w, input logic [DATA_W-1:0] word);
        send_request(KIND_CONTAINER, $urandom_range(0, ENTRIES - 1), w, rand64(), rand64(),
                     word);
    endtask

    // only the closing word of a container
    task automatic send_tail(input int digit);
        send_word(effective_words() - 1, container_word(digit, effective_words() - 1));
    endtask

    // whole container aimed at one entry, optionally with gaps, repeats and strays
    task automatic send_container(input int digit, input bit sloppy);
        int unsigned n;
        n = effective_words();
        for (int w = 0; w < n; w++) begin
            if (sloppy && w != n - 1) begin
                case ($urandom_range(0, 5))
                    0: continue;
                    1: send_word(w, container_word(digit, w));
                    2: if (n < WORDS) send_word($urandom_range(n, WORDS - 1), rand64());
                    3: load_word($urandom_range(0, ENTRIES - 1), $urandom_range(0, WORDS - 1),
                                 rand64(), rand_key());
                    default: ;
                endcase
            end
            send_word(w, container_word(digit, w));
        end
    endtask

    task automatic send_byte(input int hundreds, input int tens, input int units,
            input bit sloppy);
        send_container(hundreds, sloppy);
        send_container(tens, sloppy);
        send_container(units, sloppy);
    endtask

    task automatic send_random_byte();
        int unsigned limit;
        int          digit;
        limit = (cfg_entry_count < ENTRIES) ? cfg_entry_count : ENTRIES;
        for (int pos = 0; pos < DIGITS_PER_BYTE; pos++) begin
            if (limit == 0 || $urandom_range(0, 9) == 0)
                digit = $urandom_range(0, 1) ? -1 : $urandom_range(0, ENTRIES - 1);
            else if (pos == 0 && $urandom_range(0, 3) != 0)
                digit = $urandom_range(0, (limit > 3) ? 2 : limit - 1);
            else
                digit = $urandom_range(0, limit - 1);
            send_container(digit, $urandom_range(0, 4) == 0);
        end
    endtask

    // register write, also tracked by the predictor
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        if (idx == CFG_ENTRY_COUNT)
            cfg_entry_count = value & ((1 << ENTRY_COUNT_W) - 1);
        else if (idx == CFG_CONTAINER_WORDS)
            cfg_container_words = value & ((1 << CONTAINER_WORDS_W) - 1);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering, collect every outstanding byte, let the row empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_registers(input int unsigned n_entries, input int unsigned n_words);
        wait_idle();
        write_register(CFG_ENTRY_COUNT, n_entries);
        write_register(CFG_CONTAINER_WORDS, n_words);
    endtask

    // every table word written once, with the all-ones and empty-key corners
    task automatic load_table();
        logic [DATA_W-1:0] etalon;
        logic [DATA_W-1:0] key;
        for (int e = 0; e < ENTRIES; e++) begin
            for (int w = 0; w < WORDS; w++) begin
                etalon = rand64();
                key    = rand64();
                if (e == 0 && w == 0) begin
                    etalon = '1;
                    key    = '1;
                end else if (e == ENTRIES - 1 && w == WORDS - 1) begin
                    etalon = '1;
                    key    = '0;
                end
                load_word(e, w, etalon, key);
            end
        end
    endtask

    // reset settings, closing words only, writes to spare indexes
    task automatic test_reset_settings();
        send_tail(2);
        send_tail(5);
        send_tail(5);
        wait_idle();
        write_register(CFG_SPARE_2, 31);
        write_register(CFG_SPARE_3, 0);
        // entry 12 lies beyond the reset search range
        send_tail(0);
        send_tail(0);
        send_tail(12);
    endtask

    // byte boundaries and the all-ones container word
    task automatic test_digit_range();
        set_registers(ENTRIES, 1);
        send_byte(2, 5, 6, 1'b0);
        send_byte(15, 15, 15, 1'b0);
        send_word(0, '1);
        send_word(0, '1);
        send_word(0, '1);
    endtask

    // empty, saturated and single-entry search ranges
    task automatic test_entry_limits();
        set_registers(0, 1);
        send_byte(0, 1, 2, 1'b0);
        set_registers(31, 1);
        send_byte(0, 15, 15, 1'b0);
        set_registers(1, 1);
        send_byte(0, 0, -1, 1'b0);
    endtask

    // zero and oversized container lengths, word beyond the container
    task automatic test_container_lengths();
        set_registers(ENTRIES, 0);
        send_word(5, rand64());
        send_byte(1, 0, 0, 1'b0);
        set_registers(ENTRIES, 31);
        send_tail(1);
        send_tail(0);
        send_tail(1);
    endtask

    task automatic run_random_phase(input int unsigned n_entries, input int unsigned n_words,
            input int unsigned goal);
        int unsigned stop_at;
        set_registers(n_entries, n_words);
        stop_at = decode_items + goal;
        while (decode_items < stop_at) begin
            case ($urandom_range(0, 19))
                0, 1: load_word($urandom_range(0, ENTRIES - 1), $urandom_range(0, WORDS - 1),
                                rand64(), rand_key());
                2: send_word($urandom_range(0, effective_words() - 1), rand64());
                default: send_random_byte();
            endcase
        end
    endtask

    task automatic test_random_phases();
        int unsigned phase_entries [8] = '{10, 16, 31, 0, 1, 16, 5, 12};
        int unsigned phase_words [8]   = '{8, 1, 3, 2, 8, 15, 0, 5};
        for (int p = 0; p < 8; p++)
            run_random_phase(phase_entries[p], phase_words[p], 130);
    endtask

    // result side holds off long while requests keep coming
    task automatic test_backpressure();
        set_registers(ENTRIES, 1);
        idle_on  <= 1'b0;
        hold_req <= ~hold_req;
        repeat (50) send_random_byte();
        idle_on <= 1'b1;
    endtask

    task automatic test_steady_stream();
        idle_on <= 1'b0;
        run_random_phase(ENTRIES, 2, 220);
    endtask

    // result side: random stall bursts and the long hold-off
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD - 1;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each delivered byte with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected result: byte_value %0d status %0d", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.byte_value) begin
                    $error("byte_value: expected %0d, got %0d", want.byte_value, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("masked_match_byte_decoder_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_table();
        test_reset_settings();
        test_digit_range();
        test_entry_limits();
        test_container_lengths();
        test_random_phases();
        test_backpressure();
        test_steady_stream();
        wait_idle();
        if (pending_bytes.size() != 0) begin
            $error("%0d predicted bytes never delivered", pending_bytes.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("masked_match_byte_decoder_unit: match");
        end else begin
            $display("masked_match_byte_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/mmbd_pkg.sv
design/mmbd_cell.sv
design/mmbd_assemble.sv
design/masked_match_byte_decoder_unit.sv
tb/tb_masked_match_byte_decoder_unit.sv
